// ===== src/fpfa_pkg.sv =====
package fpfa_pkg;

   // Table geometry and field widths.
   localparam int NumParts  = 16;
   localparam int IdxBits   = 4;
   localparam int SizeBits  = 16;
   localparam int CountBits = 5;
   localparam int ModeBits  = 2;
   localparam int CmdBits   = 2;

   // Stream payload widths (tdata padded up to whole bytes).
   localparam int ReqDataBits = 24;
   localparam int RspDataBits = 24;

   // Configuration port.
   localparam int CsrIdxBits  = 1;
   localparam int CsrDataBits = 5;

   typedef enum logic [CmdBits-1:0] {
      CMD_LOAD    = 2'd0,
      CMD_RESTORE = 2'd1,
      CMD_ALLOC   = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [ModeBits-1:0] {
      MODE_FIRST  = 2'd0,
      MODE_BEST   = 2'd1,
      MODE_WORST  = 2'd2,
      MODE_SPARE  = 2'd3
   } mode_type;

   typedef enum logic [CsrIdxBits-1:0] {
      CSR_FIT_MODE    = 1'd0,
      CSR_BLOCK_COUNT = 1'd1
   } csr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic latch;      // capture the incoming item and clear the scan
      logic scan_step;  // examine one partition
      logic commit;     // apply side effects and load the result register
   } ctrl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic is_alloc;
      logic limit_zero;
      logic scan_last;
      logic out_free;
   } dp_stat_type;

endpackage

// ===== src/fpfa_ctrl.sv =====
module fpfa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  fpfa_pkg::dp_stat_type stat,
   output fpfa_pkg::ctrl_cmd_type cmd
);

   fpfa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fpfa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_tready    = 1'b0;
      cmd.latch     = 1'b0;
      cmd.scan_step = 1'b0;
      cmd.commit    = 1'b0;
      case (state_ff)
         fpfa_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = fpfa_pkg::ST_SCAN;
            end
         end
         fpfa_pkg::ST_SCAN: begin
            if (!stat.is_alloc || stat.limit_zero) begin
               state_in = fpfa_pkg::ST_DONE;
            end else begin
               cmd.scan_step = 1'b1;
               if (stat.scan_last) begin
                  state_in = fpfa_pkg::ST_DONE;
               end
            end
         end
         fpfa_pkg::ST_DONE: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = fpfa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fpfa_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/fpfa_dp.sv =====
module fpfa_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [fpfa_pkg::CsrIdxBits-1:0]      csr_index,
   input  logic [fpfa_pkg::CsrDataBits-1:0]     csr_wdata,
   input  logic [fpfa_pkg::CmdBits-1:0]         in_command,
   input  logic [fpfa_pkg::IdxBits-1:0]         in_block_index,
   input  logic [fpfa_pkg::SizeBits-1:0]        in_size_value,
   input  fpfa_pkg::ctrl_cmd_type               cmd,
   output fpfa_pkg::dp_stat_type                stat,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic                                 out_granted,
   output logic [fpfa_pkg::IdxBits-1:0]         out_block_number,
   output logic [fpfa_pkg::SizeBits-1:0]        out_leftover
);

   // Configuration registers.
   logic [fpfa_pkg::ModeBits-1:0]  fit_mode_ff;
   logic [fpfa_pkg::CountBits-1:0] block_count_ff;

   // Partition table.
   logic [fpfa_pkg::SizeBits-1:0] sizes_ff [fpfa_pkg::NumParts];
   logic [fpfa_pkg::NumParts-1:0] used_ff;

   // Current item.
   fpfa_pkg::cmd_type              cmd_ff;
   logic [fpfa_pkg::IdxBits-1:0]   idx_ff;
   logic [fpfa_pkg::SizeBits-1:0]  req_size_ff;
   logic [fpfa_pkg::CountBits-1:0] limit_ff;

   // Scan state.
   logic [fpfa_pkg::IdxBits-1:0]   cnt_ff;
   logic                           found_ff;
   logic [fpfa_pkg::IdxBits-1:0]   pick_ff;
   logic [fpfa_pkg::SizeBits-1:0]  pick_size_ff;

   // Result register.
   logic                           rsp_valid_ff;
   logic                           granted_ff;
   logic [fpfa_pkg::IdxBits-1:0]   number_ff;
   logic [fpfa_pkg::SizeBits-1:0]  leftover_ff;

   logic [fpfa_pkg::CountBits-1:0] limit_in;
   logic [fpfa_pkg::SizeBits-1:0]  scan_size;
   logic                           fits;
   logic                           take;
   logic                           grant_now;

   // A block count above the table size acts as the table size.
   assign limit_in = (block_count_ff > fpfa_pkg::CountBits'(fpfa_pkg::NumParts))
                     ? fpfa_pkg::CountBits'(fpfa_pkg::NumParts) : block_count_ff;

   assign scan_size = sizes_ff[cnt_ff];
   assign fits      = !used_ff[cnt_ff] && (scan_size >= req_size_ff);
   // Strict compares keep ties on the lowest index; an unused mode acts as first fit.
   assign take      = fits && (!found_ff ||
                       (fit_mode_ff == fpfa_pkg::MODE_BEST  && scan_size < pick_size_ff) ||
                       (fit_mode_ff == fpfa_pkg::MODE_WORST && scan_size > pick_size_ff));
   assign grant_now = (cmd_ff == fpfa_pkg::CMD_ALLOC) && found_ff;

   assign stat.is_alloc   = (cmd_ff == fpfa_pkg::CMD_ALLOC);
   assign stat.limit_zero = (limit_ff == '0);
   assign stat.scan_last  = ({1'b0, cnt_ff} == (limit_ff - 1'b1));
   assign stat.out_free   = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff    <= '0;
         block_count_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            fpfa_pkg::CSR_FIT_MODE:    fit_mode_ff    <= csr_wdata[fpfa_pkg::ModeBits-1:0];
            fpfa_pkg::CSR_BLOCK_COUNT: block_count_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fpfa_pkg::NumParts; i++) begin
            sizes_ff[i] <= '0;
         end
         used_ff <= '0;
      end else if (cmd.commit) begin
         case (cmd_ff)
            fpfa_pkg::CMD_LOAD:    sizes_ff[idx_ff] <= req_size_ff;
            fpfa_pkg::CMD_RESTORE: used_ff <= '0;
            fpfa_pkg::CMD_ALLOC: begin
               if (found_ff) begin
                  used_ff[pick_ff] <= 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff   <= fpfa_pkg::CMD_NONE;
         found_ff <= 1'b0;
         cnt_ff   <= '0;
         limit_ff <= '0;
      end else if (cmd.latch) begin
         cmd_ff   <= fpfa_pkg::cmd_type'(in_command);
         found_ff <= 1'b0;
         cnt_ff   <= '0;
         limit_ff <= limit_in;
      end else if (cmd.scan_step) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (take) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         idx_ff       <= in_block_index;
         req_size_ff  <= in_size_value;
         pick_ff      <= '0;
         pick_size_ff <= '0;
      end else if (cmd.scan_step && take) begin
         pick_ff      <= cnt_ff;
         pick_size_ff <= scan_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         granted_ff  <= grant_now;
         number_ff   <= grant_now ? pick_ff : '0;
         leftover_ff <= grant_now ? (pick_size_ff - req_size_ff) : '0;
      end
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign out_granted      = granted_ff;
   assign out_block_number = number_ff;
   assign out_leftover     = leftover_ff;

   // A committed grant marks its partition used.
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit && grant_now |=> used_ff[$past(pick_ff)])
      else $error("granted partition not marked used");

   // A held pick always fits the request, so the leftover never wraps.
   assert property (@(posedge clock) disable iff (reset)
      found_ff |-> pick_size_ff >= req_size_ff)
      else $error("picked partition smaller than request");

   // The scan never looks past the latched limit.
   assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> {1'b0, cnt_ff} < limit_ff)
      else $error("scan beyond partition limit");

   // A result is only loaded when the result register can take it.
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten");

endmodule

// ===== src/fixed_partition_fit_allocator.sv =====
// Fixed-partition fit allocator. The block holds a table of sixteen partitions,
// each with a loaded size and a used mark, and takes one command item at a time on
// the req_ stream: load a partition size, restore every partition to free, or
// allocate a request by first, best or worst fit over the lowest block_count
// partitions (ties go to the lowest index). Every item produces exactly one result
// item on the rsp_ stream; only a successful allocation sets granted, and then the
// result carries the partition number and the leftover size, otherwise both are
// zero. An allocation walks the lowest min(block_count, 16) partitions one entry
// per cycle through a single compare unit; load, restore and the unused command
// code skip the scan. The result sits in an output register, and the block takes
// its next item while that result still waits, stalling only when a second result
// is ready before the first is taken. Configuration registers are to be written
// through the csr_ port only while no item is in progress; the block itself does
// not enforce this. Index 0 is the fit mode, index 1 the partition count.
module fixed_partition_fit_allocator (
   input  logic                                  clock,
   input  logic                                  reset,
   // Command stream.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [fpfa_pkg::ReqDataBits-1:0]      req_tdata,  // block_index[3:0], size_value[19:4]
   input  logic [fpfa_pkg::CmdBits-1:0]          req_tuser,  // command[1:0]
   // Result stream.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [fpfa_pkg::RspDataBits-1:0]      rsp_tdata,  // block_number[3:0], leftover[19:4]
   output logic                                  rsp_tuser,  // granted[0]
   // Configuration writes.
   input  logic                                  csr_we,
   input  logic [fpfa_pkg::CsrIdxBits-1:0]       csr_index,
   input  logic [fpfa_pkg::CsrDataBits-1:0]      csr_wdata
);

   localparam int SizeLo = fpfa_pkg::IdxBits;
   localparam int SizeHi = fpfa_pkg::IdxBits + fpfa_pkg::SizeBits - 1;
   localparam int PadBits = fpfa_pkg::RspDataBits - fpfa_pkg::IdxBits - fpfa_pkg::SizeBits;

   fpfa_pkg::ctrl_cmd_type cmd;
   fpfa_pkg::dp_stat_type  stat;

   logic [fpfa_pkg::IdxBits-1:0]  out_block_number;
   logic [fpfa_pkg::SizeBits-1:0] out_leftover;

   // The controller sequences accept, scan and commit; the datapath owns the table.
   fpfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   fpfa_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .in_command       (req_tuser),
      .in_block_index   (req_tdata[fpfa_pkg::IdxBits-1:0]),
      .in_size_value    (req_tdata[SizeHi:SizeLo]),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .out_granted      (rsp_tuser),
      .out_block_number (out_block_number),
      .out_leftover     (out_leftover)
   );

   // Upper tdata bits are padding and read as zero.
   assign rsp_tdata = {{PadBits{1'b0}}, out_leftover, out_block_number};

endmodule
